### rtl/core/ogsm_pkg.sv
// Shared types and constants of the output gain smoother and peak meter.
package ogsm_pkg;

   localparam int CHANNELS    = 4;
   localparam int CHAN_BITS   = 2;
   localparam int SAMPLE_BITS = 24;
   localparam int GAIN_BITS   = 24;
   localparam int GAIN_FRAC   = 22;
   localparam int MASK_BITS   = 4;
   localparam int CSR_BITS    = 3;

   localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int SCALED_BITS = PROD_BITS - GAIN_FRAC;

   localparam int COEF_BITS   = 16;
   localparam int DIFF_BITS   = GAIN_BITS + 1;
   localparam int DPROD_BITS  = DIFF_BITS + COEF_BITS;
   localparam int STEP_FRAC   = 24;
   localparam int STEP_BITS   = DPROD_BITS - STEP_FRAC;
   localparam int GSUM_BITS   = GAIN_BITS + 2;

   typedef logic [CHAN_BITS-1:0]          chan_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SAMPLE_BITS-1:0]        level_type;
   typedef logic [GAIN_BITS-1:0]          gain_type;
   typedef logic [MASK_BITS-1:0]          mask_type;

   localparam gain_type   GAIN_ONE   = gain_type'(1 << GAIN_FRAC);
   localparam gain_type   GAIN_MAX   = '1;
   localparam logic signed [COEF_BITS-1:0] SMOOTH_COEF = 16'sd16777;
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [CSR_BITS-1:0] {
      REG_GAIN0    = 3'd0,
      REG_GAIN1    = 3'd1,
      REG_GAIN2    = 3'd2,
      REG_GAIN3    = 3'd3,
      REG_GAIN_EN  = 3'd4,
      REG_MUTE_EN  = 3'd5,
      REG_MUTE     = 3'd6,
      REG_POLARITY = 3'd7
   } csr_index_type;

endpackage

### rtl/core/ogsm_if.sv
// Request and response channel interfaces of the output gain smoother and peak meter.
interface ogsm_req_if;
   logic                 valid;
   logic                 ready;
   ogsm_pkg::chan_type   chan;
   ogsm_pkg::sample_type sample_in;
   logic                 frame_end;

   modport source (output valid, chan, sample_in, frame_end, input ready);
   modport sink   (input valid, chan, sample_in, frame_end, output ready);
endinterface

interface ogsm_rsp_if;
   logic                 valid;
   logic                 ready;
   ogsm_pkg::chan_type   chan_out;
   ogsm_pkg::sample_type sample_out;
   ogsm_pkg::level_type  peak_level;
   logic                 peak_valid;

   modport source (output valid, chan_out, sample_out, peak_level, peak_valid, input ready);
   modport sink   (input valid, chan_out, sample_out, peak_level, peak_valid, output ready);
endinterface

### rtl/core/output_gain_smoother_meter_top.sv
// Output gain smoother and peak meter: top level.
//
// Each request carries one signed Q1.23 sample, its channel and a frame-end
// mark. The sample is scaled by the channel's smoothed gain, saturated and,
// if the channel's polarity bit is set, negated. The smoothed gain then takes
// one one-pole step toward its target (0 when muted, the channel gain when
// gains are enabled, 1.0 otherwise). A per-channel peak of |output| is reported
// with the frame-end sample and cleared.
// Channels: req_port (sink) and rsp_port (source), valid/ready; one response
// per request. Registers are to be written through csr_we/csr_index/csr_wdata
// only while the block is idle; the block itself does not enforce this.
// Path: a request is taken into the input register, then moves on into the
// response register.
// Throughput: one request per cycle while responses are taken; the per-channel
// gain and peak state are read and updated between those two registers.
// Reset sets gains and smoothed gains to 1.0, clears peaks, enables and masks.
// When the receiver stalls, the response holds and one more request is taken
// into the input register; req_port.ready then drops until the stall clears.
module output_gain_smoother_meter_top (
   input  logic                          clock,
   input  logic                          reset,
   ogsm_req_if.sink                      req_port,
   ogsm_rsp_if.source                    rsp_port,
   input  logic                          csr_we,
   input  ogsm_pkg::csr_index_type       csr_index,
   input  logic [ogsm_pkg::GAIN_BITS-1:0] csr_wdata
);

   // configuration
   ogsm_pkg::gain_type   gain_ff [ogsm_pkg::CHANNELS];
   logic                 gain_en_ff;
   logic                 mute_en_ff;
   ogsm_pkg::mask_type   mute_mask_ff;
   ogsm_pkg::mask_type   pol_mask_ff;

   // per-channel state
   ogsm_pkg::gain_type   gain_sm_ff [ogsm_pkg::CHANNELS];
   ogsm_pkg::level_type  peak_ff [ogsm_pkg::CHANNELS];

   // input register
   logic                 s1_valid_ff;
   ogsm_pkg::chan_type   s1_chan_ff;
   ogsm_pkg::sample_type s1_sample_ff;
   logic                 s1_fend_ff;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   ogsm_pkg::chan_type   chan_out_ff;
   ogsm_pkg::sample_type sample_out_ff;
   ogsm_pkg::sample_type sample_out_in;
   ogsm_pkg::level_type  peak_level_ff;
   ogsm_pkg::level_type  peak_level_in;
   logic                 peak_valid_ff;

   logic                 adv;
   logic                 chan_ok;
   logic                 s1_load;

   ogsm_pkg::gain_type                       gain_cur;
   ogsm_pkg::gain_type                       target;
   logic signed [ogsm_pkg::PROD_BITS-1:0]    prod;
   logic signed [ogsm_pkg::PROD_BITS-1:0]    prod_rnd;
   logic signed [ogsm_pkg::SCALED_BITS-1:0]  scaled;
   ogsm_pkg::sample_type                     y_sat;
   ogsm_pkg::level_type                      mag;
   ogsm_pkg::level_type                      peak_cur;
   ogsm_pkg::level_type                      peak_new;
   ogsm_pkg::level_type                      peak_in;
   logic signed [ogsm_pkg::DIFF_BITS-1:0]    diff;
   logic signed [ogsm_pkg::DPROD_BITS-1:0]   dprod;
   logic signed [ogsm_pkg::DPROD_BITS-1:0]   dprod_rnd;
   logic signed [ogsm_pkg::STEP_BITS-1:0]    step;
   logic signed [ogsm_pkg::GSUM_BITS-1:0]    gsum;
   ogsm_pkg::gain_type                       gain_sm_in;

   assign chan_ok = (int'(s1_chan_ff) < ogsm_pkg::CHANNELS);
   assign adv     = s1_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign s1_load = req_port.valid && req_port.ready;

   assign req_port.ready      = !s1_valid_ff || adv;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.chan_out   = chan_out_ff;
   assign rsp_port.sample_out = sample_out_ff;
   assign rsp_port.peak_level = peak_level_ff;
   assign rsp_port.peak_valid = peak_valid_ff;

   assign rsp_valid_in = (rsp_valid_ff && !rsp_port.ready) || (adv && chan_ok);

   // sample path
   always_comb begin
      gain_cur = gain_sm_ff[s1_chan_ff];
      prod     = ogsm_pkg::PROD_BITS'(s1_sample_ff)
                 * ogsm_pkg::PROD_BITS'($signed({1'b0, gain_cur}));
      prod_rnd = prod + (ogsm_pkg::PROD_BITS'(1) <<< (ogsm_pkg::GAIN_FRAC - 1));
      scaled   = prod_rnd[ogsm_pkg::PROD_BITS-1:ogsm_pkg::GAIN_FRAC];
      if (scaled[ogsm_pkg::SCALED_BITS-1:ogsm_pkg::SAMPLE_BITS-1]
          == {(ogsm_pkg::SCALED_BITS-ogsm_pkg::SAMPLE_BITS+1){scaled[ogsm_pkg::SCALED_BITS-1]}})
      begin
         y_sat = scaled[ogsm_pkg::SAMPLE_BITS-1:0];
      end else if (scaled[ogsm_pkg::SCALED_BITS-1]) begin
         y_sat = ogsm_pkg::SAMPLE_MIN;
      end else begin
         y_sat = ogsm_pkg::SAMPLE_MAX;
      end
      if (!pol_mask_ff[s1_chan_ff]) begin
         sample_out_in = y_sat;
      end else if (y_sat == ogsm_pkg::SAMPLE_MIN) begin
         sample_out_in = ogsm_pkg::SAMPLE_MAX;
      end else begin
         sample_out_in = -y_sat;
      end
      // most negative value maps to 2^(N-1) as unsigned
      mag      = sample_out_in[ogsm_pkg::SAMPLE_BITS-1] ? (~sample_out_in + 1'b1)
                                                        : sample_out_in;
      peak_cur = peak_ff[s1_chan_ff];
      peak_new = (mag > peak_cur) ? mag : peak_cur;
      if (s1_fend_ff) begin
         peak_level_in = peak_new;
         peak_in       = '0;
      end else begin
         peak_level_in = '0;
         peak_in       = peak_new;
      end
   end

   // gain smoothing
   always_comb begin
      priority if (mute_en_ff && mute_mask_ff[s1_chan_ff]) begin
         target = '0;
      end else if (gain_en_ff) begin
         target = gain_ff[s1_chan_ff];
      end else begin
         target = ogsm_pkg::GAIN_ONE;
      end
      diff      = $signed({1'b0, target}) - $signed({1'b0, gain_cur});
      dprod     = ogsm_pkg::DPROD_BITS'(diff) * ogsm_pkg::DPROD_BITS'(ogsm_pkg::SMOOTH_COEF);
      dprod_rnd = dprod + (ogsm_pkg::DPROD_BITS'(1) <<< (ogsm_pkg::STEP_FRAC - 1));
      step      = dprod_rnd[ogsm_pkg::DPROD_BITS-1:ogsm_pkg::STEP_FRAC];
      gsum      = $signed({2'b00, gain_cur}) + ogsm_pkg::GSUM_BITS'(step);
      if (gsum[ogsm_pkg::GSUM_BITS-1]) begin
         gain_sm_in = '0;
      end else if (gsum[ogsm_pkg::GSUM_BITS-2]) begin
         gain_sm_in = ogsm_pkg::GAIN_MAX;
      end else begin
         gain_sm_in = gsum[ogsm_pkg::GAIN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < ogsm_pkg::CHANNELS; c++) begin
            gain_ff[c]    <= ogsm_pkg::GAIN_ONE;
            gain_sm_ff[c] <= ogsm_pkg::GAIN_ONE;
            peak_ff[c]    <= '0;
         end
         gain_en_ff   <= 1'b0;
         mute_en_ff   <= 1'b0;
         mute_mask_ff <= '0;
         pol_mask_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ogsm_pkg::REG_GAIN0:    gain_ff[0]   <= csr_wdata;
               ogsm_pkg::REG_GAIN1:    gain_ff[1]   <= csr_wdata;
               ogsm_pkg::REG_GAIN2:    gain_ff[2]   <= csr_wdata;
               ogsm_pkg::REG_GAIN3:    gain_ff[3]   <= csr_wdata;
               ogsm_pkg::REG_GAIN_EN:  gain_en_ff   <= csr_wdata[0];
               ogsm_pkg::REG_MUTE_EN:  mute_en_ff   <= csr_wdata[0];
               ogsm_pkg::REG_MUTE:     mute_mask_ff <= csr_wdata[ogsm_pkg::MASK_BITS-1:0];
               ogsm_pkg::REG_POLARITY: pol_mask_ff  <= csr_wdata[ogsm_pkg::MASK_BITS-1:0];
            endcase
         end
         if (adv && chan_ok) begin
            gain_sm_ff[s1_chan_ff] <= gain_sm_in;
            peak_ff[s1_chan_ff]    <= peak_in;
         end
         s1_valid_ff  <= s1_load || (s1_valid_ff && !adv);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_chan_ff   <= req_port.chan;
         s1_sample_ff <= req_port.sample_in;
         s1_fend_ff   <= req_port.frame_end;
      end
      if (adv && chan_ok) begin
         chan_out_ff   <= s1_chan_ff;
         sample_out_ff <= sample_out_in;
         peak_level_ff <= peak_level_in;
         peak_valid_ff <= s1_fend_ff;
      end
   end

   a_adv_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      adv && chan_ok |=> rsp_valid_ff)
      else $error("accepted request did not reach the response register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_port.ready |-> !req_port.ready)
      else $error("request taken while both registers are full and stalled");

   a_peak_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !peak_valid_ff |-> peak_level_ff == '0)
      else $error("peak level nonzero outside frame end");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the output gain smoother and peak meter.
`timescale 1ns / 100ps

module tb_top;
   import ogsm_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 9;
   localparam int MAX_PRINTS    = 20;

   typedef struct packed {
      chan_type   chan;
      sample_type sample;
      logic       frame_end;
   } sample_req_type;

   typedef struct packed {
      chan_type   chan;
      sample_type sample;
      level_type  peak;
      logic       peak_valid;
   } meter_out_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   gain_type      csr_wdata;

   ogsm_req_if req_bus();
   ogsm_rsp_if rsp_bus();

   output_gain_smoother_meter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow and per-channel state of the predictor
   gain_type  gain_reg [CHANNELS];
   logic      gain_en;
   logic      mute_en;
   mask_type  mute_mask;
   mask_type  pol_mask;
   gain_type  gain_state [CHANNELS];
   level_type peak_hold [CHANNELS];

   sample_req_type sample_backlog [$];
   meter_out_type  expected_outputs [$];

   int          error_count;
   int          sent_count;
   int          checked_count;
   int          peak_count;
   int          clip_count;
   int          settings_count;
   int unsigned cycle_count;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stall_phase;
   logic [15:0] ready_bits;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clip_sample(longint v);
      if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
      if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
      return v;
   endfunction

   function automatic meter_out_type predict_output(sample_req_type req);
      meter_out_type res;
      longint        gain;
      longint        level;
      longint        target;
      longint        delta;
      longint        mag;
      int            c;
      c     = int'(req.chan);
      gain  = longint'(gain_state[c]);
      level = clip_sample((longint'(req.sample) * gain + (longint'(1) << 21)) >>> 22);
      if (pol_mask[c]) level = clip_sample(-level);

      if (mute_en && mute_mask[c]) target = 0;
      else if (gain_en) target = longint'(gain_reg[c]);
      else target = longint'(GAIN_ONE);
      delta = target - gain;
      gain  = gain + ((delta * longint'(SMOOTH_COEF) + (longint'(1) << 23)) >>> 24);
      if (gain < 0) gain = 0;
      if (gain > longint'(GAIN_MAX)) gain = longint'(GAIN_MAX);
      gain_state[c] = gain_type'(gain);

      mag = (level < 0) ? -level : level;
      if (mag > longint'(peak_hold[c])) peak_hold[c] = level_type'(mag);

      res.chan       = req.chan;
      res.sample     = sample_type'(level);
      res.peak_valid = req.frame_end;
      res.peak       = '0;
      if (req.frame_end) begin
         res.peak     = peak_hold[c];
         peak_hold[c] = '0;
      end
      return res;
   endfunction

   task automatic flag_mismatch(string what, longint got, longint want);
      if (error_count < MAX_PRINTS)
         $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic write_reg(csr_index_type idx, gain_type data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_GAIN_EN:  gain_en   = data[0];
         REG_MUTE_EN:  mute_en   = data[0];
         REG_MUTE:     mute_mask = data[MASK_BITS-1:0];
         REG_POLARITY: pol_mask  = data[MASK_BITS-1:0];
         default:      gain_reg[int'(idx)] = data;
      endcase
   endtask

   // narrow registers get random upper bits, which must be dropped
   task automatic apply_settings(gain_type gains [CHANNELS], logic ge, logic me,
                                 mask_type mm, mask_type pm);
      gain_type junk;
      junk = gain_type'($urandom);
      write_reg(REG_GAIN0, gains[0]);
      write_reg(REG_GAIN1, gains[1]);
      write_reg(REG_GAIN2, gains[2]);
      write_reg(REG_GAIN3, gains[3]);
      write_reg(REG_GAIN_EN, {junk[GAIN_BITS-1:1], ge});
      write_reg(REG_MUTE_EN, {junk[GAIN_BITS-2:0], me});
      write_reg(REG_MUTE, {junk[GAIN_BITS-1:MASK_BITS], mm});
      write_reg(REG_POLARITY, {junk[GAIN_BITS-5:0], pm});
      @(posedge clock);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   task automatic queue_sample(chan_type chan, sample_type sample, logic frame_end);
      sample_req_type req;
      req.chan      = chan;
      req.sample    = sample;
      req.frame_end = frame_end;
      sample_backlog.push_back(req);
   endtask

   task automatic wait_idle();
      while (sample_backlog.size() != 0 || expected_outputs.size() != 0)
         @(posedge clock);
   endtask

   function automatic gain_type pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return GAIN_MAX;
         2:       return GAIN_ONE;
         default: return gain_type'($urandom);
      endcase
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return sample_type'(int'($urandom_range(0, 64)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_outputs.push_back(predict_output(sample_backlog.pop_front()));
            sent_count++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (sample_backlog.size() != 0) begin
            req_bus.valid     <= 1'b1;
            req_bus.chan      <= sample_backlog[0].chan;
            req_bus.sample_in <= sample_backlog[0].sample;
            req_bus.frame_end <= sample_backlog[0].frame_end;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stall pattern
   always @(posedge clock) begin
      meter_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outputs.size() == 0) begin
            flag_mismatch("unexpected response, chan", rsp_bus.chan_out, -1);
         end else begin
            want = expected_outputs.pop_front();
            checked_count++;
            if (rsp_bus.chan_out !== want.chan)
               flag_mismatch("chan_out", rsp_bus.chan_out, want.chan);
            if (rsp_bus.sample_out !== want.sample)
               flag_mismatch("sample_out", rsp_bus.sample_out, want.sample);
            if (rsp_bus.peak_valid !== want.peak_valid)
               flag_mismatch("peak_valid", rsp_bus.peak_valid, want.peak_valid);
            if (rsp_bus.peak_level !== want.peak)
               flag_mismatch("peak_level", rsp_bus.peak_level, want.peak);
            if (want.peak_valid) peak_count++;
            if (want.sample == SAMPLE_MAX || want.sample == SAMPLE_MIN) clip_count++;
         end
      end
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0:       ready_bits = '1;
            1:       ready_bits = 16'($urandom) | 16'($urandom);
            2:       ready_bits = 16'($urandom);
            default: ready_bits = (16'($urandom) & 16'($urandom)) | 16'h0101;
         endcase
      end
      rsp_bus.ready <= ready_bits[stall_phase];
      stall_phase = (stall_phase + 1) % 16;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, expected_outputs.size());
         $display("output_gain_smoother_meter_top test failed");
         $finish;
      end
   end

   initial begin
      gain_type gains [CHANNELS];
      int       n_items;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = REG_GAIN0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.chan      = '0;
      req_bus.sample_in = '0;
      req_bus.frame_end = 1'b0;
      rsp_bus.ready     = 1'b1;
      stall_phase       = 0;
      ready_bits        = '1;
      gain_en           = 1'b0;
      mute_en           = 1'b0;
      mute_mask         = '0;
      pol_mask          = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         gain_reg[c]   = GAIN_ONE;
         gain_state[c] = GAIN_ONE;
         peak_hold[c]  = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unity gain, most negative sample peaks at 2^23
      queue_sample(2'd0, SAMPLE_MAX, 1'b0);
      queue_sample(2'd0, SAMPLE_MIN, 1'b1);
      queue_sample(2'd1, '0, 1'b1);
      queue_sample(2'd2, -24'sd1, 1'b0);
      queue_sample(2'd3, 24'sd1, 1'b1);
      queue_sample(2'd2, 24'sh555555, 1'b1);
      wait_idle();

      // mute beats gain, inverted channels, gains at both ends
      gains = '{GAIN_MAX, '0, GAIN_MAX, GAIN_ONE};
      apply_settings(gains, 1'b1, 1'b1, 4'b0100, 4'b1010);
      queue_sample(2'd1, SAMPLE_MIN, 1'b0);
      queue_sample(2'd1, SAMPLE_MAX, 1'b1);
      queue_sample(2'd3, SAMPLE_MIN, 1'b1);
      queue_sample(2'd2, SAMPLE_MAX, 1'b0);
      queue_sample(2'd0, SAMPLE_MAX, 1'b0);
      queue_sample(2'd0, SAMPLE_MIN, 1'b1);
      queue_sample(2'd2, 24'sh2aaaaa, 1'b1);
      for (int c = 0; c < CHANNELS; c++)
         queue_sample(chan_type'(c), pick_sample(), 1'($urandom_range(0, 1)));
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            gains = '{GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX};
            apply_settings(gains, 1'b1, 1'b0, 4'b0000, 4'b1111);
         end else if (p == 1) begin
            gains = '{GAIN_MAX, '0, GAIN_ONE, GAIN_MAX};
            apply_settings(gains, 1'b1, 1'b1, 4'b1111, 4'b0000);
         end else begin
            for (int c = 0; c < CHANNELS; c++) gains[c] = pick_gain();
            apply_settings(gains, 1'($urandom), 1'($urandom),
                           mask_type'($urandom), mask_type'($urandom));
         end
         n_items = $urandom_range(90, 130);
         for (int i = 0; i < n_items; i++)
            queue_sample(chan_type'($urandom), pick_sample(), $urandom_range(0, 5) == 0);
         wait_idle();
      end

      repeat (4) @(posedge clock);
      if (expected_outputs.size() != 0)
         flag_mismatch("leftover responses", 0, expected_outputs.size());
      $display("%0d requests under %0d register settings, %0d responses checked",
               sent_count, settings_count, checked_count);
      $display("%0d frame peaks reported, %0d outputs at full scale", peak_count, clip_count);
      if (error_count == 0) begin
         $display("output_gain_smoother_meter_top test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("output_gain_smoother_meter_top test failed");
      end
      $finish;
   end

endmodule
